/* design/sprau_pkg.sv */
`default_nettype none

package sprau_pkg;

    localparam int BOARD_SIDE = 8;
    localparam int NUM_SQUARES = BOARD_SIDE * BOARD_SIDE;
    localparam int SQ_W = $clog2(NUM_SQUARES);
    localparam int COORD_W = $clog2(BOARD_SIDE);
    localparam int NUM_DIRS = 4;
    localparam int DIR_W = $clog2(NUM_DIRS);
    localparam int RAY_LEN = BOARD_SIDE - 1;
    localparam int STEP_W = $clog2(BOARD_SIDE);
    // coordinate plus two guard bits: overflow past the edge or underflow below zero
    localparam int WIDE_W = COORD_W + 2;

    localparam logic OP_ROOK = 1'b0;
    localparam logic OP_BISHOP = 1'b1;

    typedef logic [1:0] delta_t;
    localparam delta_t DELTA_ZERO = 2'b00;
    localparam delta_t DELTA_POS = 2'b01;
    localparam delta_t DELTA_NEG = 2'b10;

    localparam delta_t ROOK_DR [NUM_DIRS] = '{DELTA_ZERO, DELTA_ZERO, DELTA_POS, DELTA_NEG};
    localparam delta_t ROOK_DF [NUM_DIRS] = '{DELTA_POS, DELTA_NEG, DELTA_ZERO, DELTA_ZERO};
    localparam delta_t BISHOP_DR [NUM_DIRS] = '{DELTA_POS, DELTA_POS, DELTA_NEG, DELTA_NEG};
    localparam delta_t BISHOP_DF [NUM_DIRS] = '{DELTA_POS, DELTA_NEG, DELTA_POS, DELTA_NEG};

    typedef logic [NUM_DIRS-1:0][RAY_LEN-1:0] ray_bits_t;

    typedef struct packed {
        logic            on_board;
        logic [SQ_W-1:0] idx;
    } ray_pos_t;

    function automatic logic [WIDE_W-1:0] step_coord(
        input logic [COORD_W-1:0] c,
        input delta_t             delta,
        input logic [STEP_W-1:0]  step
    );
        logic [WIDE_W-1:0] base;
        logic [WIDE_W-1:0] span;
        base = {2'b00, c};
        span = {2'b00, step};
        case (delta)
            DELTA_POS: step_coord = base + span;
            DELTA_NEG: step_coord = base - span;
            default:   step_coord = base;
        endcase
    endfunction

    // square reached after a given number of steps along one direction
    function automatic ray_pos_t ray_pos(
        input logic              kind,
        input logic [SQ_W-1:0]   sq,
        input logic [DIR_W-1:0]  dir,
        input logic [STEP_W-1:0] step
    );
        delta_t            dr;
        delta_t            df;
        logic [WIDE_W-1:0] r;
        logic [WIDE_W-1:0] f;
        ray_pos_t          p;
        dr = (kind == OP_ROOK) ? ROOK_DR[dir] : BISHOP_DR[dir];
        df = (kind == OP_ROOK) ? ROOK_DF[dir] : BISHOP_DF[dir];
        r = step_coord(sq[SQ_W-1:COORD_W], dr, step);
        f = step_coord(sq[COORD_W-1:0], df, step);
        p.on_board = (r[WIDE_W-1:COORD_W] == 2'b00) && (f[WIDE_W-1:COORD_W] == 2'b00);
        p.idx = {r[COORD_W-1:0], f[COORD_W-1:0]};
        return p;
    endfunction

endpackage

`default_nettype wire

/* design/sliding_piece_ray_attacks_unit.sv */
`default_nettype none
// done: the accepted start beat runs through v1_reg and v2_reg into done_reg, a strobe that lasts one cycle
// throughput: one item per cycle, busy stays low since nothing can stall
// stages: ray gather, blocker walk, scatter onto the board
// reset: rst_n clears the valid bits and done; no state is kept between items

module sliding_piece_ray_attacks_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              opcode,
    input  wire logic [sprau_pkg::SQ_W-1:0]        square,
    input  wire logic [sprau_pkg::NUM_SQUARES-1:0] occupancy,
    output logic                                   done,
    output logic [sprau_pkg::NUM_SQUARES-1:0]      attack_set
);
    import sprau_pkg::*;

    logic                  accept;
    logic                  v1_reg;
    logic                  v2_reg;
    logic                  done_reg;
    logic                  kind1_reg;
    logic                  kind2_reg;
    logic [SQ_W-1:0]       sq1_reg;
    logic [SQ_W-1:0]       sq2_reg;
    ray_bits_t             hits;
    logic [NUM_SQUARES-1:0] attack_next;
    logic [NUM_SQUARES-1:0] attack_set_reg;

    assign busy = 1'b0;
    assign accept = start & ~busy;

    sprau_ray_walk u_walk (
        .clk       (clk),
        .opcode    (opcode),
        .square    (square),
        .occupancy (occupancy),
        .hits      (hits)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    // origin travels alongside the walk so stage 3 can place the hits
    always_ff @(posedge clk)
    begin
        kind1_reg <= opcode;
        sq1_reg <= square;
        kind2_reg <= kind1_reg;
        sq2_reg <= sq1_reg;
        attack_set_reg <= attack_next;
    end

    // stage 3: scatter ray hits back onto the board
    always_comb
    begin
        ray_pos_t p;
        attack_next = '0;
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            for (int k = 0; k < RAY_LEN; k++)
            begin
                p = ray_pos(kind2_reg, sq2_reg, DIR_W'(d), STEP_W'(k + 1));
                if (hits[d][k])
                begin
                    attack_next[p.idx] = 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign attack_set = attack_set_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("accepted beat did not produce a result after three cycles");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 3))
        else $error("result without a matching input beat");

    a_origin_clear: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (attack_set[$past(square, 3)] == 1'b0))
        else $error("origin square marked as attacked");

    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (attack_set != '0))
        else $error("empty attack set from a sliding piece");

endmodule

`default_nettype wire

/* design/sprau_ray_walk.sv */
`default_nettype none

module sprau_ray_walk (
    input  wire logic                           clk,
    input  wire logic                           opcode,
    input  wire logic [sprau_pkg::SQ_W-1:0]     square,
    input  wire logic [sprau_pkg::NUM_SQUARES-1:0] occupancy,
    output sprau_pkg::ray_bits_t                hits
);
    import sprau_pkg::*;

    ray_bits_t on_next;
    ray_bits_t on_reg;
    ray_bits_t occ_next;
    ray_bits_t occ_reg;
    ray_bits_t hits_next;
    ray_bits_t hits_reg;

    // stage 1: pull the squares of each ray out of the board
    always_comb
    begin
        ray_pos_t p;
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            for (int k = 0; k < RAY_LEN; k++)
            begin
                p = ray_pos(opcode, square, DIR_W'(d), STEP_W'(k + 1));
                on_next[d][k] = p.on_board;
                occ_next[d][k] = p.on_board & occupancy[p.idx];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        on_reg <= on_next;
        occ_reg <= occ_next;
    end

    // stage 2: walk each ray up to and including the first blocker
    always_comb
    begin
        logic blocked;
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            blocked = 1'b0;
            for (int k = 0; k < RAY_LEN; k++)
            begin
                hits_next[d][k] = on_reg[d][k] & ~blocked;
                blocked = blocked | occ_reg[d][k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hits_reg <= hits_next;
    end

    assign hits = hits_reg;

endmodule

`default_nettype wire

/* sim/ray_attack_checker.sv */
`default_nettype none

module ray_attack_checker
    import sprau_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic                   busy,
    input  wire logic                   opcode,
    input  wire logic [SQ_W-1:0]        square,
    input  wire logic [NUM_SQUARES-1:0] occupancy,
    input  wire logic                   done,
    input  wire logic [NUM_SQUARES-1:0] attack_set,
    output int                          mismatches,
    output int                          outstanding,
    output int                          sets_compared
);

    logic [NUM_SQUARES-1:0] expected_attacks[$];

    // walk each ray outward until the edge or the first occupied square
    function automatic logic [NUM_SQUARES-1:0] sliding_attacks(
        input logic                   kind,
        input logic [SQ_W-1:0]        sq,
        input logic [NUM_SQUARES-1:0] occ
    );
        logic [NUM_SQUARES-1:0] hits;
        int                     dr[NUM_DIRS];
        int                     df[NUM_DIRS];
        int                     r;
        int                     f;
        bit                     blocked;
        hits = '0;
        if (kind == OP_ROOK)
        begin
            dr = '{0, 0, 1, -1};
            df = '{1, -1, 0, 0};
        end
        else
        begin
            dr = '{1, 1, -1, -1};
            df = '{1, -1, 1, -1};
        end
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            r = sq / BOARD_SIDE + dr[d];
            f = sq % BOARD_SIDE + df[d];
            blocked = 1'b0;
            while (!blocked && r >= 0 && r < BOARD_SIDE && f >= 0 && f < BOARD_SIDE)
            begin
                hits[r * BOARD_SIDE + f] = 1'b1;
                blocked = occ[r * BOARD_SIDE + f];
                r += dr[d];
                f += df[d];
            end
        end
        return hits;
    endfunction

    initial
    begin
        mismatches = 0;
        outstanding = 0;
        sets_compared = 0;
    end

    always @(posedge clk)
    begin
        logic [NUM_SQUARES-1:0] want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_attacks.size() == 0)
                begin
                    $display("%0t: attack set %h with no query waiting", $time, attack_set);
                    mismatches++;
                end
                else
                begin
                    want = expected_attacks.pop_front();
                    sets_compared++;
                    if (attack_set !== want)
                    begin
                        $display("%0t: attack_set mismatch, expected %h, actual %h",
                                 $time, want, attack_set);
                        mismatches++;
                    end
                end
            end
            // query beat
            if (start && !busy)
                expected_attacks.push_back(sliding_attacks(opcode, square, occupancy));
            outstanding = expected_attacks.size();
        end
    end

endmodule

`default_nettype wire

/* sim/sliding_piece_ray_attacks_unit_test.sv */
`default_nettype none

module sliding_piece_ray_attacks_unit_test;
    import sprau_pkg::*;

    localparam int QUERY_COUNT = 1450;
    localparam int STALL_LIMIT = 2000;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   opcode;
    logic [SQ_W-1:0]        square;
    logic [NUM_SQUARES-1:0] occupancy;
    wire logic              busy;
    wire logic              done;
    wire logic [NUM_SQUARES-1:0] attack_set;

    int mismatches;
    int outstanding;
    int sets_compared;
    int rook_queries;
    int bishop_queries;
    int origin_occupied;
    int stall_cycles;
    bit gaps_on;

    sliding_piece_ray_attacks_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .square     (square),
        .occupancy  (occupancy),
        .done       (done),
        .attack_set (attack_set)
    );

    ray_attack_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .square        (square),
        .occupancy     (occupancy),
        .done          (done),
        .attack_set    (attack_set),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .sets_compared (sets_compared)
    );

    always #6 clk = ~clk;

    // called at a falling edge, returns at the falling edge after the beat
    task automatic issue_query(
        input logic                   kind,
        input logic [SQ_W-1:0]        sq,
        input logic [NUM_SQUARES-1:0] occ
    );
        while (gaps_on && $urandom_range(99) < 31)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        opcode <= kind;
        square <= sq;
        occupancy <= occ;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (kind == OP_ROOK)
            rook_queries++;
        else
            bishop_queries++;
        if (occ[sq])
            origin_occupied++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [NUM_SQUARES-1:0] random_board(input logic [SQ_W-1:0] sq);
        logic [NUM_SQUARES-1:0] a;
        logic [NUM_SQUARES-1:0] b;
        logic [NUM_SQUARES-1:0] c;
        logic [NUM_SQUARES-1:0] occ;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       occ = '0;
            1:       occ = '1;
            2, 3:    occ = a & b & c;
            4, 5:    occ = a & b;
            6, 7:    occ = a;
            default: occ = a | b;
        endcase
        if ($urandom_range(3) == 0)
            occ[sq] = ~occ[sq];
        return occ;
    endfunction

    // watchdog on cycles with no beat on either side
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("sliding_piece_ray_attacks_unit_test: done, errors");
        $finish;
    end

    initial
    begin
        logic [SQ_W-1:0]        sq;
        logic [NUM_SQUARES-1:0] one_hot;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        opcode = OP_ROOK;
        square = '0;
        occupancy = '0;
        rook_queries = 0;
        bishop_queries = 0;
        origin_occupied = 0;
        gaps_on = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // corners and center on empty and full boards, back to back
        issue_query(OP_ROOK, 6'd0, '0);
        issue_query(OP_BISHOP, 6'd0, '0);
        issue_query(OP_ROOK, 6'd63, '0);
        issue_query(OP_BISHOP, 6'd63, '0);
        issue_query(OP_ROOK, 6'd7, '0);
        issue_query(OP_BISHOP, 6'd56, '0);
        issue_query(OP_ROOK, 6'd27, '0);
        issue_query(OP_BISHOP, 6'd36, '0);
        issue_query(OP_ROOK, 6'd0, '1);
        issue_query(OP_BISHOP, 6'd63, '1);
        issue_query(OP_ROOK, 6'd35, '1);
        issue_query(OP_BISHOP, 6'd28, '1);
        // only the origin occupied: its own bit must not block anything
        one_hot = '0;
        one_hot[27] = 1'b1;
        issue_query(OP_ROOK, 6'd27, one_hot);
        issue_query(OP_BISHOP, 6'd27, one_hot);
        one_hot = '0;
        one_hot[63] = 1'b1;
        issue_query(OP_BISHOP, 6'd63, one_hot);
        // full board but the origin: every ray stops one step out
        issue_query(OP_ROOK, 6'd20, ~(64'd1 << 20));
        issue_query(OP_BISHOP, 6'd20, ~(64'd1 << 20));
        // blockers right at the far edge squares
        issue_query(OP_ROOK, 6'd24, 64'h8000_0000_0000_0081);
        issue_query(OP_BISHOP, 6'd3, 64'h8100_0000_0000_0000);
        drain_results();

        gaps_on = 1'b1;
        for (int n = 0; n < QUERY_COUNT; n++)
        begin
            // a stretch of back-to-back beats in the middle of the run
            gaps_on = !(n >= 900 && n < 1150);
            if (n == 700)
                drain_results();
            sq = SQ_W'($urandom_range(NUM_SQUARES - 1));
            issue_query(1'($urandom_range(1)), sq, random_board(sq));
        end

        drain_results();
        repeat (8) @(posedge clk);
        $display("covered %0d rook and %0d bishop queries, %0d with the origin occupied",
                 rook_queries, bishop_queries, origin_occupied);
        $display("%0d attack sets compared, %0d mismatches", sets_compared, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("sliding_piece_ray_attacks_unit_test: done, clean");
        else
            $display("sliding_piece_ray_attacks_unit_test: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
